FILE: design/bmpd_pkg.sv
// Shared types and constants of the BMP to ARGB stream decoder.
`timescale 1ns / 1ps

package bmpd_pkg;

  // Largest accepted width and absolute height.
  localparam int unsigned MAX_DIM = 4096;

  localparam logic [31:0] HDR_LEN      = 32'd54;
  localparam logic [31:0] POS_MAGIC_B  = 32'd0;
  localparam logic [31:0] POS_MAGIC_M  = 32'd1;
  localparam logic [31:0] POS_OFFSET   = 32'd10;
  localparam logic [31:0] POS_WIDTH    = 32'd18;
  localparam logic [31:0] POS_HEIGHT   = 32'd22;
  localparam logic [31:0] POS_BPP      = 32'd28;
  localparam logic [31:0] POS_JUDGE    = 32'd53;
  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

  localparam logic [7:0]  MAGIC_B      = 8'h42;
  localparam logic [7:0]  MAGIC_M      = 8'h4D;
  localparam logic [15:0] BPP24        = 16'd24;
  localparam logic [15:0] BPP32        = 16'd32;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_MAGIC     = 3'd2;
  localparam logic [2:0] ST_SIZE      = 3'd3;
  localparam logic [2:0] ST_DEPTH     = 3'd4;
  localparam logic [2:0] ST_OFFSET    = 3'd5;
  localparam logic [2:0] ST_TRUNCATED = 3'd6;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] argb;
    logic [2:0]  code;
    logic [12:0] w;
    logic [12:0] h;
    logic        alpha;
    logic        last;
  } bmpd_result_t;

  // Results produced by one accepted byte: a pixel, a status, or both.
  typedef struct packed {
    logic         pix_valid;
    logic         stat_valid;
    bmpd_result_t pix;
    bmpd_result_t stat;
  } bmpd_push_t;

endpackage

FILE: design/bmpd_parser.sv
// Header parser and pixel assembler: updates the decoder state once per accepted byte.
`timescale 1ns / 1ps

module bmpd_parser
  import bmpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output bmpd_push_t push
);

  logic [31:0] byte_count, byte_count_next;
  logic        magic_ok, magic_ok_next;
  logic [31:0] pixel_offset, pixel_offset_next;
  logic [31:0] raw_width, raw_width_next;
  logic [31:0] raw_height, raw_height_next;
  logic [15:0] bits_per_pixel, bits_per_pixel_next;
  logic [13:0] row_byte_count, row_byte_count_next;
  logic [12:0] rows_done, rows_done_next;
  logic [23:0] pixel_bytes, pixel_bytes_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [2:0]  header_error, header_error_next;
  logic [11:0] col, col_next;

  logic [31:0] abs_h32;
  logic [12:0] h13;
  logic [2:0]  judge;
  logic [2:0]  eff_err;
  logic        is32;
  logic [2:0]  bpb;
  logic [14:0] w15, dlen, stride, row_inc;
  logic        active, in_data, pix_done;
  logic [12:0] y13;
  logic [31:0] argb;
  logic        short_file, report_dims;
  logic [2:0]  code;
  logic [1:0]  lane;

  assign abs_h32 = raw_height[31] ? (~raw_height + 32'd1) : raw_height;
  assign h13     = abs_h32[12:0];
  assign is32    = (bits_per_pixel == BPP32);
  assign bpb     = is32 ? 3'd4 : 3'd3;
  assign w15     = {2'b00, raw_width[12:0]};
  assign dlen    = is32 ? (w15 << 2) : (w15 + (w15 << 1));
  assign stride  = (dlen + 15'd3) & ~15'd3;
  assign row_inc = {1'b0, row_byte_count} + 15'd1;
  assign y13     = h13 - 13'd1 - rows_done;

  always_comb begin
    if (!magic_ok) begin
      judge = ST_MAGIC;
    end else if (raw_width[31] || (raw_width == 32'd0) || (raw_width > MAX_DIM) ||
                 (abs_h32 == 32'd0) || (abs_h32 > MAX_DIM)) begin
      judge = ST_SIZE;
    end else if ((bits_per_pixel != BPP24) && (bits_per_pixel != BPP32)) begin
      judge = ST_DEPTH;
    end else if (pixel_offset < HDR_LEN) begin
      judge = ST_OFFSET;
    end else begin
      judge = ST_OK;
    end
  end

  assign active = (byte_count >= HDR_LEN) && (header_error == ST_OK) &&
                  (byte_count >= pixel_offset) && (rows_done < h13);
  assign in_data  = ({1'b0, row_byte_count} < dlen);
  assign pix_done = in_data && ({1'b0, byte_in_pixel} >= (bpb - 3'd1));
  assign argb     = is32 ? {data_byte, pixel_bytes} :
                           {ALPHA_OPAQUE, data_byte, pixel_bytes[15:0]};
  assign lane     = byte_count[1:0] - POS_OFFSET[1:0];

  always_comb begin
    byte_count_next     = (byte_count != COUNT_MAX) ? byte_count + 32'd1 : byte_count;
    magic_ok_next       = magic_ok;
    pixel_offset_next   = pixel_offset;
    raw_width_next      = raw_width;
    raw_height_next     = raw_height;
    bits_per_pixel_next = bits_per_pixel;
    row_byte_count_next = row_byte_count;
    rows_done_next      = rows_done;
    pixel_bytes_next    = pixel_bytes;
    byte_in_pixel_next  = byte_in_pixel;
    header_error_next   = header_error;
    col_next            = col;

    if (byte_count == POS_MAGIC_B) begin
      magic_ok_next = (data_byte == MAGIC_B);
    end else if (byte_count == POS_MAGIC_M) begin
      magic_ok_next = magic_ok && (data_byte == MAGIC_M);
    end else if ((byte_count >= POS_OFFSET) && (byte_count <= POS_OFFSET + 32'd3)) begin
      pixel_offset_next[{lane, 3'b000} +: 8] = data_byte;
    end else if ((byte_count >= POS_WIDTH) && (byte_count <= POS_WIDTH + 32'd3)) begin
      raw_width_next[{byte_count[1:0] - POS_WIDTH[1:0], 3'b000} +: 8] = data_byte;
    end else if ((byte_count >= POS_HEIGHT) && (byte_count <= POS_HEIGHT + 32'd3)) begin
      raw_height_next[{byte_count[1:0] - POS_HEIGHT[1:0], 3'b000} +: 8] = data_byte;
    end else if ((byte_count == POS_BPP) || (byte_count == POS_BPP + 32'd1)) begin
      bits_per_pixel_next[{byte_count[0], 3'b000} +: 8] = data_byte;
    end else if (byte_count == POS_JUDGE) begin
      header_error_next = judge;
    end else if (active) begin
      if (in_data) begin
        if (pix_done) begin
          byte_in_pixel_next = 2'd0;
          pixel_bytes_next   = 24'd0;
          col_next           = col + 12'd1;
        end else begin
          pixel_bytes_next[{byte_in_pixel, 3'b000} +: 8] = data_byte;
          byte_in_pixel_next = byte_in_pixel + 2'd1;
        end
      end
      row_byte_count_next = row_inc[13:0];
      if (row_inc == dlen) begin
        rows_done_next = rows_done + 13'd1;
      end
      if (row_inc >= stride) begin
        row_byte_count_next = 14'd0;
        col_next            = 12'd0;
      end
    end
  end

  // Status result on the last byte. The header is judged in this same cycle at byte 53.
  assign eff_err     = (byte_count == POS_JUDGE) ? judge : header_error;
  assign short_file  = (byte_count < POS_JUDGE);
  assign report_dims = !short_file && (eff_err == ST_OK);

  always_comb begin
    if (short_file) begin
      code = ST_SHORT;
    end else if (eff_err != ST_OK) begin
      code = eff_err;
    end else if (pixel_offset > byte_count) begin
      code = ST_OFFSET;
    end else if (rows_done_next < h13) begin
      code = ST_TRUNCATED;
    end else begin
      code = ST_OK;
    end
  end

  // Pixel result and status result of this byte.
  always_comb begin
    push.pix       = '0;
    push.pix.kind  = KIND_PIXEL;
    push.pix.x     = col;
    push.pix.y     = raw_height[31] ? rows_done[11:0] : y13[11:0];
    push.pix.argb  = argb;
    push.pix_valid = in_fire && (byte_count != POS_MAGIC_B) && (byte_count > POS_JUDGE) &&
                     active && pix_done;

    push.stat       = '0;
    push.stat.kind  = KIND_STATUS;
    push.stat.code  = code;
    push.stat.w     = report_dims ? raw_width[12:0] : 13'd0;
    push.stat.h     = report_dims ? h13 : 13'd0;
    push.stat.alpha = report_dims && is32;
    push.stat.last  = 1'b1;
    push.stat_valid = in_fire && last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst || (in_fire && last_byte)) begin
      byte_count     <= '0;
      magic_ok       <= 1'b0;
      pixel_offset   <= '0;
      raw_width      <= '0;
      raw_height     <= '0;
      bits_per_pixel <= '0;
      row_byte_count <= '0;
      rows_done      <= '0;
      pixel_bytes    <= '0;
      byte_in_pixel  <= '0;
      header_error   <= ST_OK;
      col            <= '0;
    end else if (in_fire) begin
      byte_count     <= byte_count_next;
      magic_ok       <= magic_ok_next;
      pixel_offset   <= pixel_offset_next;
      raw_width      <= raw_width_next;
      raw_height     <= raw_height_next;
      bits_per_pixel <= bits_per_pixel_next;
      row_byte_count <= row_byte_count_next;
      rows_done      <= rows_done_next;
      pixel_bytes    <= pixel_bytes_next;
      byte_in_pixel  <= byte_in_pixel_next;
      header_error   <= header_error_next;
      col            <= col_next;
    end
  end

endmodule

FILE: design/bmpd_out_fifo.sv
// Four-entry result queue that takes up to two results per cycle and hands out one.
`timescale 1ns / 1ps

module bmpd_out_fifo
  import bmpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  bmpd_push_t   push,
  output logic         room,
  output logic         out_valid,
  input  logic         out_ready,
  output bmpd_result_t out_data
);

  bmpd_result_t mem [0:3];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic [1:0] n_push;
  logic       pop;
  bmpd_result_t first;

  assign n_push    = {1'b0, push.pix_valid} + {1'b0, push.stat_valid};
  assign first     = push.pix_valid ? push.pix : push.stat;
  assign out_valid = (count != 3'd0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  // A byte may produce two results, so keep room for two.
  assign room       = (count < 3'd3);
  assign count_next = count + {1'b0, n_push} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= first;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push.stat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

endmodule

FILE: design/bmp_to_argb_stream_decoder.sv
// Top level of the BMP to ARGB stream decoder.
`timescale 1ns / 1ps

// Takes an uncompressed 24 or 32 bpp BMP file one byte per transfer, tlast on the final
// byte, and returns each pixel as an ARGB word with its column and row (rows of bottom-up
// images flipped), then one status transfer with tlast set that carries the error code,
// width, height and alpha flag. One byte is taken every cycle; the only stall comes from
// the four-entry result queue, which accepts a byte only while it has room for two
// results, so a held-off output side stops input once three or more results are pending.
// The state returns to reset after each file's last byte.
module bmp_to_argb_stream_decoder
  import bmpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_x[11:0], pixel_y[23:12], argb_word[55:24], status_code[58:56],
  // image_width[71:59], image_height[84:72], has_alpha[85], zero fill[87:86]
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tuser,   // result_kind
  output logic        m_axis_tlast    // is_last
);

  logic         in_fire;
  bmpd_push_t   push;
  bmpd_result_t head;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  bmpd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .data_byte (s_axis_tdata),
    .last_byte (s_axis_tlast),
    .push      (push)
  );

  bmpd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (head)
  );

  assign m_axis_tdata = {2'b00, head.alpha, head.h, head.w, head.code,
                         head.argb, head.y, head.x};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule
